>>> sv/hsv_to_rgb_8bit_macros.svh
// Assertion macros for the hsv_to_rgb_8bit checker.
// Depends on nothing; included by the checker file only.
`ifndef HSV_TO_RGB_8BIT_MACROS_SVH
`define HSV_TO_RGB_8BIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define H2R_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequent in the cycle after an antecedent sequence matches.
`define H2R_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/hsvrgb_pkg.sv
// Shared types, constants and divide-by-255 helpers for the HSV to RGB pipeline.
// No dependencies.
package hsvrgb_pkg;

  localparam int unsigned Scale   = 255;
  localparam int unsigned ScaleSq = 65025;

  // Hue sectors, named after the color at the start of each sector
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t    sector;
    logic [7:0] rem;
    logic [7:0] sat;
    logic [7:0] val;
  } sec_stage_t;

  typedef struct packed {
    sector_t     sector;
    logic [7:0]  val;
    logic [7:0]  p;
    logic [23:0] mq;
    logic [23:0] mt;
  } prod_stage_t;

  // floor(y/255) for y <= 65025: (y+1)*257 >> 16
  function automatic logic [7:0] div255_w16(input logic [15:0] y);
    logic [16:0] y1;
    logic [25:0] acc;
    y1  = {1'b0, y} + 17'd1;
    acc = {9'b0, y1} + {1'b0, y1, 8'b0};
    return acc[23:16];
  endfunction

  // floor(y/255) for y < 255*2^16: (y+1)*65793 >> 24
  function automatic logic [15:0] div255_w24(input logic [23:0] y);
    logic [24:0] y1;
    logic [41:0] acc;
    y1  = {1'b0, y} + 25'd1;
    acc = {17'b0, y1} + {9'b0, y1, 8'b0} + {1'b0, y1, 16'b0};
    return acc[39:24];
  endfunction

endpackage

>>> sv/hsvrgb_sector.sv
// Stage 1: split the hue into sector and remainder within the sector.
// Depends on hsvrgb_pkg.
module hsvrgb_sector (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  logic                    valid_in,
  input  logic [7:0]              hue,
  input  logic [7:0]              sat,
  input  logic [7:0]              val,
  output logic                    valid_r,
  output hsvrgb_pkg::sec_stage_t  stage_r
);
  import hsvrgb_pkg::*;

  logic [10:0] x;
  logic [10:0] base;
  logic [10:0] diff;
  sector_t     sector;
  sec_stage_t  stage_nxt;

  assign x = {1'b0, hue, 2'b0} + {2'b0, hue, 1'b0};

  // Top hue folds back to the red sector with zero remainder
  always_comb begin
    priority if (x >= 11'(6 * Scale)) begin
      sector = SEC_RED;     base = 11'(6 * Scale);
    end else if (x >= 11'(5 * Scale)) begin
      sector = SEC_MAGENTA; base = 11'(5 * Scale);
    end else if (x >= 11'(4 * Scale)) begin
      sector = SEC_BLUE;    base = 11'(4 * Scale);
    end else if (x >= 11'(3 * Scale)) begin
      sector = SEC_CYAN;    base = 11'(3 * Scale);
    end else if (x >= 11'(2 * Scale)) begin
      sector = SEC_GREEN;   base = 11'(2 * Scale);
    end else if (x >= 11'(Scale)) begin
      sector = SEC_YELLOW;  base = 11'(Scale);
    end else begin
      sector = SEC_RED;     base = 11'd0;
    end
  end

  assign diff = x - base;

  always_comb begin
    stage_nxt.sector = sector;
    stage_nxt.rem    = diff[7:0];
    stage_nxt.sat    = sat;
    stage_nxt.val    = val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

>>> sv/hsvrgb_scale.sv
// Stages 2 and 3: form the p, q and t numerators and scale them by brightness.
// Depends on hsvrgb_pkg.
module hsvrgb_scale (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     advance,
  input  logic                     valid_in,
  input  hsvrgb_pkg::sec_stage_t   stage_in,
  output logic                     valid_r,
  output hsvrgb_pkg::prod_stage_t  stage_r
);
  import hsvrgb_pkg::*;

  // stage 2
  logic [15:0]  prod_rs;
  logic [15:0]  prod_ts;
  logic [15:0]  prod_p;
  logic [7:0]   inv_rem;
  logic [7:0]   inv_sat;
  logic         s2_valid_r;
  sector_t      s2_sector_r;
  logic [7:0]   s2_val_r;
  logic [15:0]  s2_nq_r, s2_nq_nxt;
  logic [15:0]  s2_nt_r, s2_nt_nxt;
  logic [15:0]  s2_pp_r;
  // stage 3
  prod_stage_t  stage_nxt;

  assign inv_rem   = 8'(Scale) - stage_in.rem;
  assign inv_sat   = 8'(Scale) - stage_in.sat;
  assign prod_rs   = 16'(stage_in.rem) * 16'(stage_in.sat);
  assign prod_ts   = 16'(inv_rem) * 16'(stage_in.sat);
  assign prod_p    = 16'(stage_in.val) * 16'(inv_sat);
  assign s2_nq_nxt = 16'(ScaleSq) - prod_rs;
  assign s2_nt_nxt = 16'(ScaleSq) - prod_ts;

  always_comb begin
    stage_nxt.sector = s2_sector_r;
    stage_nxt.val    = s2_val_r;
    stage_nxt.p      = div255_w16(s2_pp_r);
    stage_nxt.mq     = 24'(s2_val_r) * 24'(s2_nq_r);
    stage_nxt.mt     = 24'(s2_val_r) * 24'(s2_nt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      valid_r    <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= valid_in;
      valid_r    <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_sector_r <= stage_in.sector;
      s2_val_r    <= stage_in.val;
      s2_nq_r     <= s2_nq_nxt;
      s2_nt_r     <= s2_nt_nxt;
      s2_pp_r     <= prod_p;
      stage_r     <= stage_nxt;
    end
  end

endmodule

>>> sv/hsvrgb_select.sv
// Stages 4 and 5: divide q and t by 65025 and pick the sector's channel order.
// Depends on hsvrgb_pkg; holds the output register.
module hsvrgb_select (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     advance,
  input  logic                     valid_in,
  input  hsvrgb_pkg::prod_stage_t  stage_in,
  output logic                     valid_r,
  output logic [7:0]               red_r,
  output logic [7:0]               green_r,
  output logic [7:0]               blue_r
);
  import hsvrgb_pkg::*;

  logic         s4_valid_r;
  sector_t      s4_sector_r;
  logic [7:0]   s4_val_r;
  logic [7:0]   s4_p_r;
  logic [15:0]  s4_dq_r;
  logic [15:0]  s4_dt_r;
  logic [7:0]   q;
  logic [7:0]   t;
  logic [7:0]   red_nxt, green_nxt, blue_nxt;

  assign q = div255_w16(s4_dq_r);
  assign t = div255_w16(s4_dt_r);

  always_comb begin
    unique case (s4_sector_r)
      SEC_RED:     begin red_nxt = s4_val_r; green_nxt = t;        blue_nxt = s4_p_r;   end
      SEC_YELLOW:  begin red_nxt = q;        green_nxt = s4_val_r; blue_nxt = s4_p_r;   end
      SEC_GREEN:   begin red_nxt = s4_p_r;   green_nxt = s4_val_r; blue_nxt = t;        end
      SEC_CYAN:    begin red_nxt = s4_p_r;   green_nxt = q;        blue_nxt = s4_val_r; end
      SEC_BLUE:    begin red_nxt = t;        green_nxt = s4_p_r;   blue_nxt = s4_val_r; end
      default:     begin red_nxt = s4_val_r; green_nxt = s4_p_r;   blue_nxt = q;        end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      valid_r    <= 1'b0;
    end else if (advance) begin
      s4_valid_r <= valid_in;
      valid_r    <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_sector_r <= stage_in.sector;
      s4_val_r    <= stage_in.val;
      s4_p_r      <= stage_in.p;
      s4_dq_r     <= div255_w24(stage_in.mq);
      s4_dt_r     <= div255_w24(stage_in.mt);
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      blue_r      <= blue_nxt;
    end
  end

endmodule

>>> sv/hsv_to_rgb_8bit.sv
// HSV to RGB converter, 8 bits per component, five register stages.
// A request accepted moves through the stage 1 to 4 registers and then the output register.
// Throughput: one request per cycle; the whole pipe advances together, set by the output stall.
// Reset (rst_n, synchronous, active low) clears the stage valid bits only; no clearing pass.
// Depends on hsvrgb_pkg, hsvrgb_sector, hsvrgb_scale and hsvrgb_select.
module hsv_to_rgb_8bit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_hue,
  input  logic [7:0] in_saturation,
  input  logic [7:0] in_brightness,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);
  import hsvrgb_pkg::*;

  logic         advance;
  logic         s1_valid;
  sec_stage_t   s1_stage;
  logic         s3_valid;
  prod_stage_t  s3_stage;

  // Advance every stage whenever the output slot is empty or being taken.
  // A bubble anywhere in the pipe moves along with the stages around it.
  assign advance  = !out_valid || !out_stall;
  // Hold off the sender only while the output request is blocked.
  assign in_stall = !advance;

  // Stage 1: sector and remainder from 6*hue
  hsvrgb_sector u_sector (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .valid_in (in_valid),
    .hue      (in_hue),
    .sat      (in_saturation),
    .val      (in_brightness),
    .valid_r  (s1_valid),
    .stage_r  (s1_stage)
  );

  // Stages 2 and 3: numerators of p, q, t, then scale by brightness
  hsvrgb_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .valid_in (s1_valid),
    .stage_in (s1_stage),
    .valid_r  (s3_valid),
    .stage_r  (s3_stage)
  );

  // Stages 4 and 5: truncating divide by 65025 in two /255 steps, then
  // route v, p, q, t to red, green and blue by sector
  hsvrgb_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .valid_in (s3_valid),
    .stage_in (s3_stage),
    .valid_r  (out_valid),
    .red_r    (out_red),
    .green_r  (out_green),
    .blue_r   (out_blue)
  );

endmodule

>>> sv/hsvrgb_checker.sv
// Port-level checker for hsv_to_rgb_8bit and the bind that attaches it.
// Depends on hsv_to_rgb_8bit_macros.svh.
`include "hsv_to_rgb_8bit_macros.svh"

module hsvrgb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_saturation,
  input logic [7:0] in_brightness,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  `H2R_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue), "stalled result request changed")

  `H2R_ASSERT_ALWAYS(a_in_stall_src, clk, rst_n, in_stall == (out_valid && out_stall), "input stalled without a blocked result")

  `H2R_ASSERT_NEXT(a_grey_pass, clk, rst_n, in_valid && !in_stall && in_saturation == 8'd0 ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid && out_red == $past(in_brightness, 5) && out_green == out_red && out_blue == out_red, "grey request did not pass brightness through")

endmodule

bind hsv_to_rgb_8bit hsvrgb_checker u_hsvrgb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_saturation (in_saturation),
  .in_brightness (in_brightness),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue)
);

>>> test/hsv_to_rgb_8bit_checker.sv
// Checker for hsv_to_rgb_8bit: watches both channels, predicts each color and compares it.
// Depends on hsvrgb_pkg for the sector enum and the fixed-point scale constants.
module hsv_to_rgb_8bit_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_hue,
  input  logic [7:0] in_saturation,
  input  logic [7:0] in_brightness,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_red,
  input  logic [7:0] out_green,
  input  logic [7:0] out_blue,
  output int         mismatches,
  output int         colors_outstanding
);
  import hsvrgb_pkg::*;

  localparam int unsigned HueSectors = 6;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  rgb_t colors_due[$];

  // Fixed-point HSV to RGB; every quotient truncates.
  function automatic rgb_t convert_hsv(input logic [7:0] hue, sat, val);
    int unsigned hue6;
    int unsigned offset;
    logic [7:0]  shade_p;
    logic [7:0]  shade_q;
    logic [7:0]  shade_t;
    sector_t     sec;
    rgb_t        px;
    hue6 = HueSectors * hue;
    offset = hue6 % Scale;
    // top hue wraps back to the red sector
    if (hue6 / Scale >= HueSectors) sec = SEC_RED;
    else sec = sector_t'(hue6 / Scale);
    shade_p = 8'(val * (Scale - sat) / Scale);
    shade_q = 8'(val * (ScaleSq - offset * sat) / ScaleSq);
    shade_t = 8'(val * (ScaleSq - (Scale - offset) * sat) / ScaleSq);
    case (sec)
      SEC_RED:     px = '{red: val,     green: shade_t, blue: shade_p};
      SEC_YELLOW:  px = '{red: shade_q, green: val,     blue: shade_p};
      SEC_GREEN:   px = '{red: shade_p, green: val,     blue: shade_t};
      SEC_CYAN:    px = '{red: shade_p, green: shade_q, blue: val};
      SEC_BLUE:    px = '{red: shade_t, green: shade_p, blue: val};
      default:     px = '{red: val,     green: shade_p, blue: shade_q};
    endcase
    return px;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want, got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rgb_t due;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (colors_due.size() == 0) begin
          $display("%0t: color with no request waiting, expected none actual %0d %0d %0d",
                   $time, out_red, out_green, out_blue);
          mismatches++;
        end else begin
          due = colors_due.pop_front();
          check_field("red", due.red, out_red);
          check_field("green", due.green, out_green);
          check_field("blue", due.blue, out_blue);
        end
      end
      if (in_valid && !in_stall)
        colors_due.push_back(convert_hsv(in_hue, in_saturation, in_brightness));
    end
    colors_outstanding = colors_due.size();
  end

endmodule

>>> test/tb_hsv_to_rgb_8bit.sv
// Testbench top for hsv_to_rgb_8bit: clock, reset, pixel requests, output stalls and verdict.
// Depends on hsv_to_rgb_8bit (with its package) and hsv_to_rgb_8bit_checker.
module tb_hsv_to_rgb_8bit;

  // Cycles with no request and no color accepted before the run is declared hung.
  // Longest legal quiet stretch is one long gap or stall plus the pipe depth.
  localparam int unsigned HangLimit  = 500;
  localparam int unsigned DrainDelay = 8;
  localparam int unsigned RandomPixels = 900;
  localparam int unsigned ModeSpan = 100;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_hue = 8'd0;
  logic [7:0] in_saturation = 8'd0;
  logic [7:0] in_brightness = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  int          mismatches;
  int          colors_outstanding;
  bit          gaps_on = 1'b0;
  bit          stall_on = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  // Hues at and around each sector boundary, plus both ends of the circle.
  logic [7:0] edge_hues[12] = '{8'd0, 8'd42, 8'd43, 8'd84, 8'd85, 8'd127,
                                8'd128, 8'd170, 8'd212, 8'd213, 8'd254, 8'd255};

  always #2 clk = ~clk;

  hsv_to_rgb_8bit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  hsv_to_rgb_8bit_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_hue            (in_hue),
    .in_saturation     (in_saturation),
    .in_brightness     (in_brightness),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .mismatches        (mismatches),
    .colors_outstanding(colors_outstanding)
  );

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Occasionally force a field to one of its extremes so they recur in the random part.
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Output side: stall for a random number of cycles, only while stalls are enabled.
  // Hold out_stall high until the countdown expires, then decide again.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hang detector: reset the count on any accepted request or color.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one pixel request and hold it until the block takes it.
  // With no gap, valid stays high and only the payload advances, back to back.
  task automatic send_pixel(input logic [7:0] hue, sat, val);
    int unsigned gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_brightness <= val;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every sector boundary at full saturation and brightness,
    // including the top hue that wraps to the red sector.
    foreach (edge_hues[i]) send_pixel(edge_hues[i], 8'd255, 8'd255);
    // Zero saturation gives grey, whatever the hue.
    send_pixel(8'd100, 8'd0, 8'd200);
    send_pixel(8'd255, 8'd0, 8'd255);
    // Zero brightness gives black.
    send_pixel(8'd60, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd0);
    // Mid-sector points exercise p and the sector's q or t in each sector.
    send_pixel(8'd21, 8'd128, 8'd200);
    send_pixel(8'd64, 8'd128, 8'd200);
    send_pixel(8'd106, 8'd128, 8'd200);
    send_pixel(8'd149, 8'd128, 8'd200);
    send_pixel(8'd191, 8'd128, 8'd200);
    send_pixel(8'd234, 8'd128, 8'd200);

    // Random: switch the idling pattern every stretch so some run at full rate
    // and others see gaps and stalls on either side.
    for (int unsigned n = 0; n < RandomPixels; n++) begin
      if (n % ModeSpan == 0) begin
        gaps_on = ($urandom_range(0, 2) != 0);
        stall_on <= ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 7) == 0)
        send_pixel(edge_hues[$urandom_range(0, 11)], pick_level(), pick_level());
      else
        send_pixel(pick_level(), pick_level(), pick_level());
    end
    in_valid <= 1'b0;
    stall_on <= 1'b1;

    // Drain: sample at the falling edge, away from the checker's updates.
    do @(negedge clk); while (colors_outstanding != 0);
    repeat (DrainDelay) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/hsvrgb_pkg.sv
sv/hsvrgb_sector.sv
sv/hsvrgb_scale.sv
sv/hsvrgb_select.sv
sv/hsv_to_rgb_8bit.sv
sv/hsvrgb_checker.sv
test/hsv_to_rgb_8bit_checker.sv
test/tb_hsv_to_rgb_8bit.sv
